FILE: rtl/b2da_pkg.sv
// Shared types and constants for the binary to decimal ASCII converter.
`timescale 1ns / 1ps

package b2da_pkg;

    localparam int unsigned BCD_WIDTH  = 4;
    localparam int unsigned CHAR_WIDTH = 6;

    localparam logic [BCD_WIDTH-1:0]  BCD_ADJUST_LIMIT = 4'd5;
    localparam logic [BCD_WIDTH-1:0]  BCD_ADJUST       = 4'd3;
    localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO       = 6'd48;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic clear;
        logic dabble;
        logic advance;
    } cell_ctrl_t;

endpackage

FILE: rtl/b2da_cell.sv
// One decimal digit cell of the shift-and-add-3 chain.
`timescale 1ns / 1ps

module b2da_cell
    import b2da_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cell_ctrl_t           ctrl,
    input  logic                 shift_in,
    input  logic [BCD_WIDTH-1:0] digit_in,
    output logic                 carry_out,
    output logic [BCD_WIDTH-1:0] digit
);

    logic [BCD_WIDTH-1:0] digit_reg;
    logic [BCD_WIDTH-1:0] digit_next;
    logic [BCD_WIDTH-1:0] adjusted;

    always_comb
    begin
        if (digit_reg >= BCD_ADJUST_LIMIT)
        begin
            adjusted = digit_reg + BCD_ADJUST;
        end
        else
        begin
            adjusted = digit_reg;
        end
    end

    always_comb
    begin
        priority if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.dabble)
        begin
            digit_next = {adjusted[BCD_WIDTH-2:0], shift_in};
        end
        else if (ctrl.advance)
        begin
            digit_next = digit_in;
        end
        else
        begin
            digit_next = digit_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
        end
        else
        begin
            digit_reg <= digit_next;
        end
    end

    assign carry_out = adjusted[BCD_WIDTH-1];
    assign digit     = digit_reg;

endmodule

FILE: rtl/binary_to_decimal_ascii_top.sv
// Top level of the binary to decimal ASCII converter.
// A number is taken when start is high and busy is low; busy then stays high through the
// convert and emit states, so no new number is taken until its last digit has been emitted.
// The chain of digit cells absorbs one input bit per cycle, then shifts one digit per cycle.
// Characters leave in the cycle after their emit step, most significant first, leading zeros dropped.
// Reset is asynchronous and active low; it returns the block to idle with no output pending.
`timescale 1ns / 1ps

module binary_to_decimal_ascii_top
    import b2da_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] value,
    output logic                   busy,
    output logic                   digit_valid,
    output logic [CHAR_WIDTH-1:0]  digit_char,
    output logic                   last_digit
);

    localparam int unsigned DIGITS    = ((VALUE_WIDTH * 1233) >> 12) + 1;
    localparam int unsigned BIT_CNT_W = $clog2(VALUE_WIDTH);
    localparam int unsigned DIG_CNT_W = $clog2(DIGITS + 1);

    state_t state_reg;
    state_t state_next;

    logic [VALUE_WIDTH-1:0] bin_reg;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg;
    logic [DIG_CNT_W-1:0]   dig_cnt_reg;
    logic                   started_reg;

    logic                   digit_valid_reg;
    logic                   digit_valid_next;
    logic [CHAR_WIDTH-1:0]  digit_char_reg;
    logic [CHAR_WIDTH-1:0]  digit_char_next;
    logic                   last_digit_reg;
    logic                   last_digit_next;

    logic                   accept;
    logic                   emit;
    logic                   final_digit;
    cell_ctrl_t             cell_ctrl;

    logic [DIGITS-1:0]      carry;
    logic [BCD_WIDTH-1:0]   digit [DIGITS];
    logic [BCD_WIDTH-1:0]   top_digit;

    assign accept      = start && (state_reg == ST_IDLE);
    assign top_digit   = digit[DIGITS-1];
    assign final_digit = (dig_cnt_reg == DIG_CNT_W'(1));

    for (genvar i = 0; i < DIGITS; i++)
    begin : g_cell
        logic                 cell_shift_in;
        logic [BCD_WIDTH-1:0] cell_digit_in;

        if (i == 0)
        begin : g_first
            assign cell_shift_in = bin_reg[VALUE_WIDTH-1];
            assign cell_digit_in = '0;
        end
        else
        begin : g_rest
            assign cell_shift_in = carry[i-1];
            assign cell_digit_in = digit[i-1];
        end

        b2da_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (cell_ctrl),
            .shift_in  (cell_shift_in),
            .digit_in  (cell_digit_in),
            .carry_out (carry[i]),
            .digit     (digit[i])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                if (bit_cnt_reg == '0)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (final_digit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cell_ctrl        = '0;
        emit             = 1'b0;
        digit_valid_next = 1'b0;
        last_digit_next  = 1'b0;
        digit_char_next  = ASCII_ZERO + {{(CHAR_WIDTH-BCD_WIDTH){1'b0}}, top_digit};
        unique case (state_reg)
            ST_IDLE:
            begin
                cell_ctrl.clear = start;
            end
            ST_CONVERT:
            begin
                cell_ctrl.dabble = 1'b1;
            end
            ST_EMIT:
            begin
                cell_ctrl.advance = 1'b1;
                emit              = started_reg || (top_digit != '0) || final_digit;
                digit_valid_next  = emit;
                last_digit_next   = final_digit;
            end
            default:
            begin
                cell_ctrl = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            bit_cnt_reg     <= '0;
            dig_cnt_reg     <= '0;
            started_reg     <= 1'b0;
            digit_valid_reg <= 1'b0;
            last_digit_reg  <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            digit_valid_reg <= digit_valid_next;
            last_digit_reg  <= last_digit_next;
            if (accept)
            begin
                bit_cnt_reg <= BIT_CNT_W'(VALUE_WIDTH - 1);
            end
            else if (state_reg == ST_CONVERT)
            begin
                bit_cnt_reg <= bit_cnt_reg - BIT_CNT_W'(1);
            end
            if (state_reg == ST_CONVERT)
            begin
                dig_cnt_reg <= DIG_CNT_W'(DIGITS);
                started_reg <= 1'b0;
            end
            else if (state_reg == ST_EMIT)
            begin
                dig_cnt_reg <= dig_cnt_reg - DIG_CNT_W'(1);
                started_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bin_reg <= value;
        end
        else if (state_reg == ST_CONVERT)
        begin
            bin_reg <= {bin_reg[VALUE_WIDTH-2:0], 1'b0};
        end
        digit_char_reg <= digit_char_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign digit_valid = digit_valid_reg;
    assign digit_char  = digit_char_reg;
    assign last_digit  = last_digit_reg;

    // The most significant cell must never overflow while bits are shifted in.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONVERT) |-> !carry[DIGITS-1])
        else $error("digit chain overflow");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("start transfer did not raise busy");

    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        digit_valid |-> ((digit_char >= ASCII_ZERO) && (digit_char <= ASCII_ZERO + 6'd9)))
        else $error("character is not a decimal digit");

    a_last_marked: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && final_digit) |=> (digit_valid && last_digit))
        else $error("run ended without a marked last digit");

endmodule

FILE: dv/binary_to_decimal_ascii_top_tb.sv
// Testbench for the binary to decimal ASCII converter, checked character by character.
`timescale 1ns / 1ps

module binary_to_decimal_ascii_top_tb;
    import b2da_pkg::*;

    localparam int VALUE_WIDTH    = 32;
    localparam int MAX_DIGITS     = 10;
    localparam int RANDOM_NUMBERS = 385;
    localparam int CALM_TAIL      = 60;
    localparam int STALL_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 50;

    typedef struct packed {
        logic [CHAR_WIDTH-1:0] code;
        logic                  last;
    } digit_t;

    class decimal_text_scoreboard;
        digit_t expected_digits[$];
        int     mismatches;
        int     numbers_noted;
        int     chars_checked;
        int     shortest_run;
        int     longest_run;

        function new();
            mismatches    = 0;
            numbers_noted = 0;
            chars_checked = 0;
            shortest_run  = MAX_DIGITS;
            longest_run   = 0;
        endfunction

        function int pending();
            return expected_digits.size();
        endfunction

        task report_mismatch(input string msg);
            $display("ERROR at %0t: %s", $time, msg);
            mismatches++;
        endtask

        // Splits the number into decimal digits and queues them most significant first.
        function void note_number(input logic [VALUE_WIDTH-1:0] number);
            logic [3:0]             decimal_digits[MAX_DIGITS];
            logic [VALUE_WIDTH-1:0] remainder;
            int                     count;
            digit_t                 entry;
            remainder = number;
            count = 0;
            do
            begin
                decimal_digits[count] = 4'(remainder % 10);
                remainder = remainder / 10;
                count++;
            end
            while (remainder != 0 && count < MAX_DIGITS);
            for (int k = count - 1; k >= 0; k--)
            begin
                entry.code = CHAR_WIDTH'(decimal_digits[k]) + ASCII_ZERO;
                entry.last = (k == 0);
                expected_digits.push_back(entry);
            end
            numbers_noted++;
            if (count < shortest_run)
                shortest_run = count;
            if (count > longest_run)
                longest_run = count;
        endfunction

        task check_digit(input logic [CHAR_WIDTH-1:0] code, input logic last);
            digit_t want;
            chars_checked++;
            if (expected_digits.size() == 0)
            begin
                report_mismatch($sformatf("unexpected character %0d last %0b", code, last));
                return;
            end
            want = expected_digits.pop_front();
            if (code !== want.code)
                report_mismatch($sformatf("digit_char %0d, expected %0d", code, want.code));
            if (last !== want.last)
                report_mismatch($sformatf("last_digit %0b, expected %0b", last, want.last));
        endtask
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic [VALUE_WIDTH-1:0] value;
    logic                   busy;
    logic                   digit_valid;
    logic [CHAR_WIDTH-1:0]  digit_char;
    logic                   last_digit;

    decimal_text_scoreboard sb;
    int                     stall_cycles;

    binary_to_decimal_ascii_top #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .value       (value),
        .busy        (busy),
        .digit_valid (digit_valid),
        .digit_char  (digit_char),
        .last_digit  (last_digit)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && digit_valid)
            sb.check_digit(digit_char, last_digit);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || digit_valid)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles.", STALL_LIMIT);
            $display("FAIL binary_to_decimal_ascii_top");
            $finish;
        end
    end

    // The gap is counted from the first cycle in which the block is free again.
    task idle_burst(input int cycles);
        start <= 1'b0;
        do
            @(posedge clk);
        while (busy);
        repeat (cycles - 1) @(posedge clk);
    endtask

    task send_number(input logic [VALUE_WIDTH-1:0] number);
        start <= 1'b1;
        value <= number;
        do
            @(posedge clk);
        while (busy);
        sb.note_number(number);
    endtask

    function automatic logic [VALUE_WIDTH-1:0] power_of_ten(input int exponent);
        logic [VALUE_WIDTH-1:0] result;
        result = 1;
        for (int k = 0; k < exponent; k++)
            result = result * 10;
        return result;
    endfunction

    // Numbers of a chosen digit count half the time, with fully random words, round numbers and edge values mixed in.
    function automatic logic [VALUE_WIDTH-1:0] random_number();
        int                     digits;
        logic [VALUE_WIDTH-1:0] low_bound;
        logic [VALUE_WIDTH-1:0] high_bound;
        digits = $urandom_range(1, MAX_DIGITS);
        low_bound = (digits == 1) ? '0 : power_of_ten(digits - 1);
        high_bound = (digits == MAX_DIGITS) ? '1 : power_of_ten(digits) - 1;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return $urandom_range(high_bound, low_bound);
            5, 6:          return $urandom;
            7:             return $urandom_range(4, 1) * power_of_ten($urandom_range(9, 0));
            8:             return power_of_ten(digits - 1) + $urandom_range(2, 0) - 1;
            default:       return '1 - $urandom_range(15, 0);
        endcase
    endfunction

    logic [VALUE_WIDTH-1:0] directed_numbers[] = '{
        32'd0, 32'd1, 32'd5, 32'd9, 32'd10, 32'd19, 32'd99, 32'd100, 32'd101,
        32'd1000, 32'd65535, 32'd100000, 32'd999999, 32'd1000000, 32'd10000000,
        32'd99999999, 32'd100000000, 32'd999999999, 32'd1000000000,
        32'd2147483647, 32'd2147483648, 32'd4000000000, 32'd4294967294,
        32'd4294967295, 32'h55555555
    };

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        start = 1'b0;
        value = '0;
        stall_cycles = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_numbers[i])
            send_number(directed_numbers[i]);

        for (int i = 0; i < RANDOM_NUMBERS; i++)
        begin
            if (i < RANDOM_NUMBERS - CALM_TAIL && $urandom_range(0, 2) == 0)
                idle_burst($urandom_range(1, 6));
            send_number(random_number());
        end
        start <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Converted %0d numbers into %0d characters, runs of %0d to %0d digits.",
                 sb.numbers_noted, sb.chars_checked, sb.shortest_run, sb.longest_run);
        $display("Mismatches found: %0d.", sb.mismatches);
        if (sb.mismatches == 0)
            $display("PASS binary_to_decimal_ascii_top");
        else
            $display("FAIL binary_to_decimal_ascii_top");
        $finish;
    end

endmodule

FILE: binary_to_decimal_ascii_top.f
rtl/b2da_pkg.sv
rtl/b2da_cell.sv
rtl/binary_to_decimal_ascii_top.sv
dv/binary_to_decimal_ascii_top_tb.sv
